### design/assert_macros.svh
// Assertion macros for the rational reduce block.
// Active in simulation; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPLIES(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("fail");
`define AST_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("fail");
`else
`define AST_IMPLIES(lbl, clk, rst_n, a, c)
`define AST_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

### design/rar_pkg.sv
// Package for the rational reduce block: widths, op codes, back-end state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
    localparam int OperandWidth = 16;
    localparam int ResWidth     = 33;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_MUL, t_ST_SUM, t_ST_GCD, t_ST_DIV, t_ST_OUT
    } t_state;
endpackage
`default_nettype wire

### design/rar_front.sv
// Front end: accepts requests, splits operands to sign/magnitude and picks
// the two cross-product operand pairs per op. Uses rar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rar_front #(
    parameter int OW = rar_pkg::OperandWidth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_func,
    input  wire logic [OW-1:0] i_a_num,
    input  wire logic [OW-1:0] i_a_den,
    input  wire logic [OW-1:0] i_b_num,
    input  wire logic [OW-1:0] i_b_den,
    output logic               o_q_valid,
    input  wire logic          i_q_stall,
    output logic [4*OW+5:0]    o_q_data
);
    // one-entry queue; each operand stored as sign + magnitude (OW bits)
    logic             r_full;
    logic [4*OW+5:0]  r_data;
    logic [4*OW+5:0]  n_data;
    logic [OW:0] m_an, m_ad, m_bn, m_bd;

    function automatic logic [OW:0] smag(input logic [OW-1:0] v);
        logic [OW-1:0] m;
        m = v[OW-1] ? (~v + 1'b1) : v;
        return {v[OW-1], m};
    endfunction

    assign o_stall = r_full;
    // classify: reorder so pair0=(x,y) feeds num term, pair1 feeds den (mul/div) or the second num term (add/sub)
    always_comb begin
        m_an = smag(i_a_num);
        m_ad = smag(i_a_den);
        m_bn = smag(i_b_num);
        m_bd = smag(i_b_den);
        case (i_func)
            rar_pkg::OP_MUL: n_data = {i_func, m_an, m_bn, m_ad, m_bd};
            rar_pkg::OP_DIV: n_data = {i_func, m_an, m_bd, m_ad, m_bn};
            default:         n_data = {i_func, m_an, m_bd, m_ad, m_bn};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_valid && !r_full) begin
            r_full <= 1'b1;
        end else if (r_full && !i_q_stall) begin
            r_full <= 1'b0;
        end
        if (i_valid && !r_full) begin
            r_data <= n_data;
        end
    end
    assign o_q_valid = r_full;
    assign o_q_data  = r_data;
endmodule
`default_nettype wire

### design/rar_back.sv
// Back end: products, sum, binary gcd, restoring division, result register.
// Uses rar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rar_back #(
    parameter int OW = rar_pkg::OperandWidth
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    output logic                                 o_q_stall,
    input  wire logic [4*OW+5:0]                 i_q_data,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [rar_pkg::ResWidth-1:0]  o_res_num,
    output logic signed [rar_pkg::ResWidth-1:0]  o_res_den,
    output logic                                 o_zero_den_error,
    output logic                                 o_busy
);
    localparam int MW = 2*OW + 1;            // magnitude width of sums
    localparam int CW = $clog2(MW + 1);
    localparam int SW = $clog2(MW + 1) + 1;  // shift counter
    // width for two's complement conversion, never narrower than the result
    localparam int TW = (MW + 1 > rar_pkg::ResWidth) ? MW + 1 : rar_pkg::ResWidth;

    rar_pkg::t_state r_st, n_st;
    logic [1:0]    r_op;
    logic [OW:0]   r_x0, r_y0, r_x1, r_y1;
    logic [MW-1:0] r_p, r_q, r_d;            // magnitudes
    logic          r_ps, r_qs, r_ds;
    logic [MW-1:0] r_n;                      // numerator magnitude
    logic          r_ns;
    logic [MW-1:0] r_gu, r_gv;               // gcd working values
    logic [SW-1:0] r_gk;
    logic [MW-1:0] r_g;
    logic          r_dsel;                   // 0: dividing num, 1: den
    logic [MW-1:0] r_quo, r_rem;
    logic [CW-1:0] r_cnt;
    logic signed [rar_pkg::ResWidth-1:0] r_rn, r_rd;
    logic          r_err;

    // next-state logic
    always_comb begin
        n_st = r_st;
        case (r_st)
            rar_pkg::t_ST_IDLE: if (i_q_valid) n_st = rar_pkg::t_ST_MUL;
            rar_pkg::t_ST_MUL:  n_st = rar_pkg::t_ST_SUM;
            rar_pkg::t_ST_SUM:  n_st = rar_pkg::t_ST_GCD;
            rar_pkg::t_ST_GCD: begin
                if (r_err || r_n == '0) n_st = rar_pkg::t_ST_OUT;
                else if (r_gv == '0) n_st = rar_pkg::t_ST_DIV;
            end
            rar_pkg::t_ST_DIV:
                if (r_dsel && r_cnt == CW'(MW - 1)) n_st = rar_pkg::t_ST_OUT;
            rar_pkg::t_ST_OUT:  if (!i_stall) n_st = rar_pkg::t_ST_IDLE;
            default:            n_st = rar_pkg::t_ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_stall        = (r_st != rar_pkg::t_ST_IDLE);
        o_valid          = (r_st == rar_pkg::t_ST_OUT);
        o_res_num        = r_rn;
        o_res_den        = r_rd;
        o_zero_den_error = r_err;
        o_busy           = (r_st != rar_pkg::t_ST_IDLE);
    end

    logic [MW-1:0] w_sum, w_diff, w_rdiff, w_tu, w_dv, w_sh;
    logic          w_sub_q;
    logic [MW-1:0] w_gmag;
    always_comb begin
        w_sub_q = (r_op == rar_pkg::OP_SUB) ? ~r_qs : r_qs;
        w_sum   = r_p + r_q;
        w_diff  = r_p - r_q;
        w_rdiff = r_q - r_p;
        // binary gcd step: halve u when it is even
        w_tu = r_gu;
        if (r_gu[0] == 1'b0) w_tu = r_gu >> 1;
        w_dv    = r_dsel ? r_d : r_n;
        w_sh    = {r_rem[MW-2:0], w_dv[CW'(MW - 1) - r_cnt]};
        w_gmag  = r_g;
    end

    function automatic logic [rar_pkg::ResWidth-1:0] tw(input logic s,
                                                        input logic [MW-1:0] m);
        logic [TW-1:0] v;
        v = s ? (~TW'(m) + 1'b1) : TW'(m);
        return v[rar_pkg::ResWidth-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rar_pkg::t_ST_IDLE;
        end else begin
            r_st <= n_st;
        end
        case (r_st)
            rar_pkg::t_ST_IDLE: begin
                {r_op, r_x0, r_y0, r_x1, r_y1} <= i_q_data;
            end
            rar_pkg::t_ST_MUL: begin
                // p = x0*y0, q = ad*bn (for add/sub), d = x1*y1 or den product
                r_p  <= MW'(r_x0[OW-1:0] * r_y0[OW-1:0]);
                r_ps <= r_x0[OW] ^ r_y0[OW];
                if (r_op == rar_pkg::OP_ADD || r_op == rar_pkg::OP_SUB) begin
                    // x1=ad, y1=bn: q = ad*bn, d = ad*bd
                    r_q  <= MW'(r_x1[OW-1:0] * r_y1[OW-1:0]);
                    r_qs <= r_x1[OW] ^ r_y1[OW];
                    r_d  <= MW'(r_x1[OW-1:0] * r_y0[OW-1:0]);
                    r_ds <= r_x1[OW] ^ r_y0[OW];
                end else begin
                    r_q  <= '0;
                    r_qs <= 1'b0;
                    r_d  <= MW'(r_x1[OW-1:0] * r_y1[OW-1:0]);
                    r_ds <= r_x1[OW] ^ r_y1[OW];
                end
            end
            rar_pkg::t_ST_SUM: begin
                // zero magnitude counts as positive
                if (r_ps == w_sub_q || r_q == '0 || r_p == '0) begin
                    r_n  <= w_sum;
                    r_ns <= (r_p == '0) ? (w_sub_q && r_q != '0) : r_ps;
                end else if (r_p >= r_q) begin
                    r_n  <= w_diff;
                    r_ns <= r_ps && (w_diff != '0);
                end else begin
                    r_n  <= w_rdiff;
                    r_ns <= w_sub_q;
                end
                r_err <= (r_d == '0);
                r_gu  <= (r_p == '0 && r_q == '0) ? '0
                       : ((r_ps == w_sub_q || r_q == '0 || r_p == '0) ? w_sum
                       : ((r_p >= r_q) ? w_diff : w_rdiff));
                r_gv  <= r_d;
                r_gk  <= '0;
            end
            rar_pkg::t_ST_GCD: begin
                // binary gcd: strip common twos, then subtract-and-shift
                if (r_gv != '0 && r_gu != '0) begin
                    if (r_gu[0] == 1'b0 && r_gv[0] == 1'b0) begin
                        r_gu <= r_gu >> 1;
                        r_gv <= r_gv >> 1;
                        r_gk <= r_gk + 1'b1;
                    end else if (r_gu[0] == 1'b0) begin
                        r_gu <= w_tu;
                    end else if (r_gv[0] == 1'b0) begin
                        r_gv <= r_gv >> 1;
                    end else if (r_gu >= r_gv) begin
                        r_gu <= (r_gu - r_gv) >> 1;
                    end else begin
                        r_gv <= (r_gv - r_gu) >> 1;
                    end
                end else if (r_gv == '0) begin
                    r_g <= r_gu << r_gk;
                end
                r_dsel <= 1'b0;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= '0;
                if (r_gu == '0) begin
                    r_gu <= r_gv;
                    r_gv <= '0;
                end
                if (r_err) begin
                    r_rn <= '0; r_rd <= '0;
                end else if (r_n == '0) begin
                    r_rn <= '0; r_rd <= rar_pkg::ResWidth'(1);
                end
            end
            rar_pkg::t_ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (w_sh >= w_gmag) begin
                    r_rem <= w_sh - w_gmag;
                    r_quo <= {r_quo[MW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[MW-2:0], 1'b0};
                end
                if (r_cnt == CW'(MW - 1)) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_quo <= '0;
                    if (!r_dsel) begin
                        r_rn <= tw(r_ns, {r_quo[MW-2:0], (w_sh >= w_gmag)});
                    end else begin
                        r_rd <= tw(r_ds && r_d != '0,
                                   {r_quo[MW-2:0], (w_sh >= w_gmag)});
                    end
                    r_dsel <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### design/rational_arith_reduce.sv
// Top level of the rational reduce block: front end, queue, back end.
// Depends on rar_pkg, rar_front, rar_back and assert_macros.svh.
// Flow: front register, then back-end states MUL, SUM, GCD, DIV (numerator, then
// denominator) and OUT; zero or error results skip DIV and go from GCD to OUT.
// Throughput: one request per back-end pass; front queues one request.
// Reset: synchronous active-low i_rst_n clears all control state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OperandWidth
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [1:0]                i_func,
    input  wire logic [OPERAND_WIDTH-1:0]  i_a_num,
    input  wire logic [OPERAND_WIDTH-1:0]  i_a_den,
    input  wire logic [OPERAND_WIDTH-1:0]  i_b_num,
    input  wire logic [OPERAND_WIDTH-1:0]  i_b_den,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [rar_pkg::ResWidth-1:0] o_res_num,
    output logic signed [rar_pkg::ResWidth-1:0] o_res_den,
    output logic                           o_zero_den_error
);
    logic                        w_qv, w_qs, w_busy;
    logic [4*OPERAND_WIDTH+5:0]  w_qd;
    logic                        w_zero_out;

    rar_front #(.OW(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_func, .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_q_valid(w_qv), .i_q_stall(w_qs), .o_q_data(w_qd)
    );
    rar_back #(.OW(OPERAND_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_stall(w_qs), .i_q_data(w_qd),
        .o_valid, .i_stall, .o_res_num, .o_res_den, .o_zero_den_error,
        .o_busy(w_busy)
    );

    // both result fields zero
    assign w_zero_out = (o_res_num == '0) && (o_res_den == '0);

    `AST_IMPLIES(a_err_zero, i_clk, i_rst_n, o_valid && o_zero_den_error, w_zero_out)
    `AST_IMPLIES(a_valid_busy, i_clk, i_rst_n, o_valid, w_busy)
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_res_num))
endmodule
`default_nettype wire

### dv/rational_arith_reduce_tb.sv
// Self-checking bench for rational_arith_reduce: fraction add/sub/mul/div with gcd reduction.
// Depends on rar_pkg and the rational_arith_reduce RTL; predicts each result in plain integers.
`timescale 1ns / 1ps
module rational_arith_reduce_tb;
    localparam int W = rar_pkg::OperandWidth;
    localparam int RW = rar_pkg::ResWidth;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]   func;
        logic [W-1:0] a_num;
        logic [W-1:0] a_den;
        logic [W-1:0] b_num;
        logic [W-1:0] b_den;
    } frac_req_t;

    typedef struct packed {
        logic [RW-1:0] num;
        logic [RW-1:0] den;
        logic          err;
    } frac_res_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [1:0]    i_func;
    logic [W-1:0]  i_a_num, i_a_den, i_b_num, i_b_den;
    logic          o_valid;
    logic          i_stall;
    logic signed [RW-1:0] o_res_num, o_res_den;
    logic          o_zero_den_error;

    frac_req_t pending_reqs[$];
    frac_res_t expected_fracs[$];
    int  mismatches;
    int  idle_cycles;
    bit  stim_done;
    bit  no_idle;
    bit  hold_rx;
    bit  pause_tx;
    int  tx_gap, rx_gap;
    bit  timed_out;

    rational_arith_reduce u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid), .i_stall(i_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_zero_den_error(o_zero_den_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduced fraction for one request, exact in 64-bit signed arithmetic
    function automatic frac_res_t reduce_frac(frac_req_t r);
        longint an, ad, bn, bd, n, d;
        longint unsigned g, nm, dm;
        frac_res_t res;
        an = longint'($signed(r.a_num));
        ad = longint'($signed(r.a_den));
        bn = longint'($signed(r.b_num));
        bd = longint'($signed(r.b_den));
        case (r.func)
            rar_pkg::OP_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
            rar_pkg::OP_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
            rar_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        res.err = 1'b0;
        if (d == 0) begin
            res.num = '0;
            res.den = '0;
            res.err = 1'b1;
        end else if (n == 0) begin
            res.num = '0;
            res.den = RW'(1);
        end else begin
            nm = (n < 0) ? longint'(-n) : n;
            dm = (d < 0) ? longint'(-d) : d;
            g = gcd64(nm, dm);
            n = n / longint'(g);
            d = d / longint'(g);
            res.num = n[RW-1:0];
            res.den = d[RW-1:0];
        end
        return res;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return '0;
            3: return W'($urandom_range(0, 1) ? 1 : -1);
            4, 5: return W'($signed($urandom_range(0, 40)) - 20);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic push_req(logic [1:0] f, logic [W-1:0] an, logic [W-1:0] ad,
                            logic [W-1:0] bn, logic [W-1:0] bd);
        frac_req_t r;
        r.func = f; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
        pending_reqs.push_back(r);
    endtask

    // Driver: offers queued requests, random gap bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_fracs.push_back(reduce_frac({i_func, i_a_num, i_a_den,
                                                      i_b_num, i_b_den}));
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (!pause_tx && pending_reqs.size() > 0) begin
                    frac_req_t r;
                    r = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    {i_func, i_a_num, i_a_den, i_b_num, i_b_den} <= r;
                    if (!no_idle && $urandom_range(0, 3) == 0)
                        tx_gap <= $urandom_range(1, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall bursts, compares against oldest expected result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_fracs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %0d/%0d",
                                                   o_res_num, o_res_den);
                end else begin
                    frac_res_t e;
                    e = expected_fracs.pop_front();
                    if (o_res_num !== e.num || o_res_den !== e.den
                        || o_zero_den_error !== e.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d err %0b got %0d/%0d err %0b",
                                     $signed(e.num), $signed(e.den), e.err,
                                     o_res_num, o_res_den, o_zero_den_error);
                    end
                end
            end
            if (hold_rx) begin
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 3) == 0) rx_gap <= $urandom_range(1, 6);
            end
        end
    end

    // Watchdog: cycles with no accepted request on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || hold_rx)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [W-1:0] mn, mx;
        mn = {1'b1, {(W-1){1'b0}}};
        mx = {1'b0, {(W-1){1'b1}}};
        mismatches = 0; stim_done = 0; no_idle = 0; hold_rx = 0; pause_tx = 0;
        timed_out = 0;
        i_valid = 0; i_stall = 0; i_func = '0;
        i_a_num = '0; i_a_den = '0; i_b_num = '0; i_b_den = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each op, extremes, zero denominators, zero numerators
        push_req(rar_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        push_req(rar_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        push_req(rar_pkg::OP_MUL, 16'd6, 16'd4, 16'd2, 16'd9);
        push_req(rar_pkg::OP_DIV, 16'd3, 16'd4, 16'd9, 16'd8);
        push_req(rar_pkg::OP_ADD, mn, mn, mn, mn);
        push_req(rar_pkg::OP_SUB, mn, mx, mx, mn);
        push_req(rar_pkg::OP_MUL, mn, mx, mn, mx);
        push_req(rar_pkg::OP_DIV, mx, mn, mn, mx);
        push_req(rar_pkg::OP_ADD, mx, 16'd1, mx, 16'd1);
        push_req(rar_pkg::OP_SUB, mn, 16'd1, mx, 16'd1);
        push_req(rar_pkg::OP_ADD, 16'd5, 16'd0, 16'd1, 16'd1);
        push_req(rar_pkg::OP_MUL, 16'd5, 16'd1, 16'd1, 16'd0);
        push_req(rar_pkg::OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
        push_req(rar_pkg::OP_DIV, 16'd0, 16'd3, 16'd0, 16'd7);
        push_req(rar_pkg::OP_MUL, 16'd0, 16'd3, 16'd4, 16'd7);
        push_req(rar_pkg::OP_ADD, 16'd0, 16'hFFFD, 16'd0, 16'd7);
        push_req(rar_pkg::OP_DIV, 16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFD);
        push_req(rar_pkg::OP_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_req(rar_pkg::OP_SUB, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        push_req(rar_pkg::OP_ADD, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);

        // Receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_rx = 1'b0;

        wait (pending_reqs.size() == 0 && expected_fracs.size() == 0 && !i_valid);
        for (int i = 0; i < 700; i++)
            push_req(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                     pick_operand(), pick_operand());

        // Sender pause mid-stream until everything has drained
        wait (pending_reqs.size() < 500);
        pause_tx = 1'b1;
        wait (expected_fracs.size() == 0 && !i_valid);
        repeat (250) @(posedge i_clk);
        pause_tx = 1'b0;

        wait (pending_reqs.size() < 100);
        no_idle = 1'b1;
        wait (pending_reqs.size() == 0 && !i_valid);
        stim_done = 1'b1;
        wait (expected_fracs.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_fracs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/rar_pkg.sv
design/rar_front.sv
design/rar_back.sv
design/rational_arith_reduce.sv
dv/rational_arith_reduce_tb.sv
